/* sv/tomp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tomp_pkg;

    localparam int OPT_W       = 8;
    localparam int MSS_W       = 16;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 24;

    localparam logic [OPT_W-1:0] KIND_END    = 8'd0;
    localparam logic [OPT_W-1:0] KIND_NOP    = 8'd1;
    localparam logic [OPT_W-1:0] KIND_MSS    = 8'd2;
    localparam logic [OPT_W-1:0] MSS_OPT_LEN = 8'd4;
    localparam logic [OPT_W-1:0] LEN_NO_BODY = 8'd2;

    typedef enum logic [1:0] {
        PH_KIND = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_STOP = 2'd3
    } phase_t;

    typedef struct packed {
        logic [MSS_W-1:0] mss_in;
        logic             syn_flag;
        logic             last_byte;
        logic             first_byte;
        logic [OPT_W-1:0] opt_byte;
    } tomp_item_t;

    typedef struct packed {
        logic             malformed;
        logic             end_seen;
        logic             mss_lowered;
        logic [MSS_W-1:0] mss_out;
    } tomp_result_t;

endpackage

`default_nettype wire

/* sv/tcp_option_mss_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  ports                        beat contents
// s_        in   s_tvalid/s_tready/s_tdata    option byte, syn, mss in; tuser first, tlast last
// m_        out  m_tvalid/m_tready/m_tdata    mss out and flags, one beat per option area
//
// one beat per cycle while no result is held; a result is registered once its last byte leaves the input register
// the walk state advances once per consumed byte, between the input register and the result register
// aresetn is synchronous; it empties both registers and restarts the walk
// a held result stalls only last-byte beats; other bytes keep flowing under m_tready low

module tcp_option_mss_parser (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // [7:0] opt_byte, [8] syn_flag, [24:9] mss_in, [31:25] zero
    input  wire  [tomp_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] first_byte
    input  wire                           s_tuser,
    input  wire                           s_tlast,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // [15:0] mss_out, [16] mss_lowered, [17] end_seen, [18] malformed, [23:19] zero
    output logic [tomp_pkg::M_TDATA_W-1:0] m_tdata
);
    import tomp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    tomp_item_t   in_item_reg;
    logic         out_valid_reg, out_valid_next;
    tomp_result_t out_data_reg;
    tomp_result_t step_result;
    logic         out_free;
    logic         consume;

    assign out_free = !out_valid_reg || m_tready;
    // bytes that give no result never wait on the output side
    assign consume  = in_valid_reg && (!in_item_reg.last_byte || out_free);
    assign s_tready = !in_valid_reg || consume;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = (consume && in_item_reg.last_byte) ? 1'b1
                          : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.opt_byte   <= s_tdata[OPT_W-1:0];
            in_item_reg.syn_flag   <= s_tdata[OPT_W];
            in_item_reg.mss_in     <= s_tdata[OPT_W+MSS_W:OPT_W+1];
            in_item_reg.first_byte <= s_tuser;
            in_item_reg.last_byte  <= s_tlast;
        end
        if (consume && in_item_reg.last_byte) begin
            out_data_reg <= step_result;
        end
    end

    tomp_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (consume),
        .item    (in_item_reg),
        .result  (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - $bits(tomp_result_t))'(0), out_data_reg};

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(consume && in_item_reg.last_byte))
        else $error("result raised without a last byte");

    a_item_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |=> in_valid_reg)
        else $error("held byte dropped");

    a_stall_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !consume |-> in_item_reg.last_byte && out_valid_reg && !m_tready)
        else $error("byte stalled without a blocked result");

endmodule

`default_nettype wire

/* sv/tomp_walker.sv */
`timescale 1ns / 1ps
`default_nettype none

module tomp_walker (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   step,
    input  tomp_pkg::tomp_item_t  item,
    output tomp_pkg::tomp_result_t result
);
    import tomp_pkg::*;

    phase_t           phase_reg,    phase_next;
    logic             is_mss_reg,   is_mss_next;
    logic [OPT_W-1:0] len_reg,      len_next;
    logic [OPT_W-1:0] left_reg,     left_next;
    logic [OPT_W-1:0] high_reg,     high_next;
    logic [MSS_W-1:0] mss_reg,      mss_next;
    logic             syn_reg,      syn_next;
    logic             lowered_reg,  lowered_next;
    logic             end_reg,      end_next;
    logic             malformed_reg, malformed_next;

    always_comb begin
        phase_t           ph;
        logic             is_mss;
        logic [OPT_W-1:0] len;
        logic [OPT_W-1:0] left;
        logic [OPT_W-1:0] high;
        logic [MSS_W-1:0] mss;
        logic             syn;
        logic             lowered;
        logic             endf;
        logic             malf;
        logic [MSS_W-1:0] opt_val;

        ph      = phase_reg;
        is_mss  = is_mss_reg;
        len     = len_reg;
        left    = left_reg;
        high    = high_reg;
        mss     = mss_reg;
        syn     = syn_reg;
        lowered = lowered_reg;
        endf    = end_reg;
        malf    = malformed_reg;

        // a first byte restarts the walk from the sampled mss and syn
        if (item.first_byte) begin
            ph      = PH_KIND;
            is_mss  = 1'b0;
            len     = '0;
            left    = '0;
            high    = '0;
            mss     = item.mss_in;
            syn     = item.syn_flag;
            lowered = 1'b0;
            endf    = 1'b0;
            malf    = 1'b0;
        end

        opt_val = {high, item.opt_byte};

        unique case (ph)
            PH_KIND: begin
                if (item.opt_byte == KIND_END) begin
                    endf = 1'b1;
                    ph   = PH_STOP;
                end else if (item.opt_byte != KIND_NOP) begin
                    is_mss = (item.opt_byte == KIND_MSS);
                    ph     = PH_LEN;
                end
            end
            PH_LEN: begin
                len = item.opt_byte;
                if (item.opt_byte == '0) begin
                    malf = 1'b1;
                    ph   = PH_STOP;
                end else if (item.opt_byte <= LEN_NO_BODY) begin
                    left = '0;
                    ph   = PH_KIND;
                end else begin
                    left = item.opt_byte - LEN_NO_BODY;
                    ph   = PH_BODY;
                end
            end
            PH_BODY: begin
                if (is_mss && len == MSS_OPT_LEN) begin
                    if (left == OPT_W'(2)) begin
                        high = item.opt_byte;
                    end else if (left == OPT_W'(1) && syn && opt_val < mss) begin
                        mss     = opt_val;
                        lowered = 1'b1;
                    end
                end
                left = left - OPT_W'(1);
                if (left == '0) begin
                    ph = PH_KIND;
                end
            end
            PH_STOP: begin
            end
            default: begin
            end
        endcase

        // area end stops the walk; it is malformed with a length byte or body still owed
        if (item.last_byte) begin
            if (ph == PH_LEN || ph == PH_BODY) begin
                malf = 1'b1;
            end
            ph = PH_STOP;
        end

        phase_next     = ph;
        is_mss_next    = is_mss;
        len_next       = len;
        left_next      = left;
        high_next      = high;
        mss_next       = mss;
        syn_next       = syn;
        lowered_next   = lowered;
        end_next       = endf;
        malformed_next = malf;
    end

    assign result.mss_out     = mss_next;
    assign result.mss_lowered = lowered_next;
    assign result.end_seen    = end_next;
    assign result.malformed   = malformed_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_KIND;
            is_mss_reg    <= 1'b0;
            len_reg       <= '0;
            left_reg      <= '0;
            high_reg      <= '0;
            mss_reg       <= '0;
            syn_reg       <= 1'b0;
            lowered_reg   <= 1'b0;
            end_reg       <= 1'b0;
            malformed_reg <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            is_mss_reg    <= is_mss_next;
            len_reg       <= len_next;
            left_reg      <= left_next;
            high_reg      <= high_next;
            mss_reg       <= mss_next;
            syn_reg       <= syn_next;
            lowered_reg   <= lowered_next;
            end_reg       <= end_next;
            malformed_reg <= malformed_next;
        end
    end

    a_stop_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.last_byte |=> phase_reg == PH_STOP)
        else $error("walk not stopped after last byte");

    a_body_left: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_BODY |-> left_reg != '0)
        else $error("body phase with no bytes left");

    a_mss_only_lowers: assert property (@(posedge aclk) disable iff (!aresetn)
        step && item.first_byte |=> mss_reg <= $past(item.mss_in))
        else $error("running mss above sampled mss");

    a_lowered_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(lowered_reg) && $past(aresetn) |-> $past(step && item.first_byte))
        else $error("lowered flag cleared without a first byte");

endmodule

`default_nettype wire
